[hdl/two_level_bitmap_page_allocator_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the page allocator
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define TWO_LEVEL_BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PGAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PGAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pgal_pkg.sv]
// ---------------------------------------------------------------------------
// pgal_pkg
// Shared widths, operation codes and status codes of the page allocator.
// ---------------------------------------------------------------------------
package pgal_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 13;
    localparam int PAGE_W   = 12;
    localparam int STATUS_W = 2;

    // reciprocal shift used to split a page index into group and offset
    localparam int RECIP_SHIFT = 26;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

endpackage

[hdl/pgal_req_if.sv]
// ---------------------------------------------------------------------------
// pgal_req_if
// Request channel: operation and page index with valid/ready.
// ---------------------------------------------------------------------------
interface pgal_req_if;
    logic                           valid;
    logic                           ready;
    logic [pgal_pkg::OP_W-1:0]      operation;
    logic [pgal_pkg::IDX_W-1:0]     page_index;

    modport source (output valid, operation, page_index, input ready);
    modport sink   (input valid, operation, page_index, output ready);
endinterface

[hdl/pgal_rsp_if.sv]
// ---------------------------------------------------------------------------
// pgal_rsp_if
// Response channel: allocated page, status and empty flag with valid/ready.
// ---------------------------------------------------------------------------
interface pgal_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pgal_pkg::PAGE_W-1:0]    page_index_res;
    pgal_pkg::t_status              status;
    logic                           is_empty;

    modport source (output valid, page_index_res, status, is_empty, input ready);
    modport sink   (input valid, page_index_res, status, is_empty, output ready);
endinterface

[hdl/two_level_bitmap_page_allocator_top.sv]
// ---------------------------------------------------------------------------
// two_level_bitmap_page_allocator_top
// Page allocator over group words of allocation bits plus a full-group map.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries an operation (allocate, free, query empty) and, for free,
//   a page index. o_rsp returns one response per request: allocated page,
//   status and the empty flag.
//   Throughput: one request per cycle unless the output stalls. An allocate
//   directly behind another allocate waits until the earlier one has left
//   the word stage, since the group choice needs the full map that the
//   earlier allocate updates after its word read.
//   Pipeline: input register (group select, word read), word stage
//   (modify, write back), output register.
//   Reset: page 0 is held, all other pages free, no group full; the word
//   memory needs no clearing pass, unwritten words read as reset values.
//   A stalled receiver holds the output register; the word stage and the
//   input register then fill, and i_req.ready drops.
// ---------------------------------------------------------------------------
`include "two_level_bitmap_page_allocator_top_defines.svh"

module two_level_bitmap_page_allocator_top #(
    parameter int PAGES_PER_GROUP = 64,
    parameter int PAGE_COUNT      = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pgal_req_if.sink   i_req,
    pgal_rsp_if.source o_rsp
);

    localparam int NUM_GROUPS = PAGE_COUNT / PAGES_PER_GROUP;
    localparam int USABLE     = NUM_GROUPS * PAGES_PER_GROUP;
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PW         = $clog2(PAGES_PER_GROUP);
    localparam int RECIP      = ((2 ** pgal_pkg::RECIP_SHIFT) + PAGES_PER_GROUP - 1)
                                / PAGES_PER_GROUP;
    localparam int PROD_W     = pgal_pkg::PAGE_W + 32;

    // input stage
    logic                          r_a_vld;
    logic [pgal_pkg::OP_W-1:0]     r_a_op;
    logic [pgal_pkg::IDX_W-1:0]    r_a_idx;
    // word stage
    logic                          r_b_vld;
    logic [pgal_pkg::OP_W-1:0]     r_b_op;
    logic [GW-1:0]                 r_b_grp;
    logic [pgal_pkg::PAGE_W-1:0]   r_b_idx;
    logic                          r_b_ok;
    // output stage
    logic                          r_o_vld;
    logic [pgal_pkg::PAGE_W-1:0]   r_o_page;
    pgal_pkg::t_status             r_o_status;
    logic                          r_o_empty;
    // allocator state
    logic [NUM_GROUPS-1:0]         r_full;
    logic [NUM_GROUPS-1:0]         n_full;
    logic [NUM_GROUPS-1:0]         r_nz;
    logic [NUM_GROUPS-1:0]         n_nz;
    logic                          r_one0;
    logic                          n_one0;
    logic                          n_a_vld;
    logic                          n_b_vld;
    logic                          n_o_vld;

    logic                          a_alloc;
    logic                          a_free;
    logic                          a_in_range;
    logic                          g_found;
    logic [GW-1:0]                 g_idx;
    logic [PROD_W-1:0]             a_prod;
    logic [GW-1:0]                 a_free_grp;
    logic [GW-1:0]                 a_grp;
    logic                          a_ok;
    logic                          hazard;
    logic                          out_free;
    logic                          adv_a;
    logic                          adv_b;
    logic                          rd_en;
    logic                          b_alloc;
    logic                          b_free;
    logic                          b_query;
    logic [PAGES_PER_GROUP-1:0]    word;
    logic [PAGES_PER_GROUP-1:0]    new_word;
    logic                          w_found;
    logic [PW-1:0]                 w_pos;
    logic [PW-1:0]                 f_pos;
    logic [pgal_pkg::PAGE_W-1:0]   base;
    logic                          wr_en;
    logic                          set_full;
    logic [pgal_pkg::PAGE_W-1:0]   b_page;
    pgal_pkg::t_status             b_status;
    logic                          b_empty;

    // ---- input stage: group select and word read ----
    assign a_alloc    = (r_a_op == pgal_pkg::OP_ALLOC);
    assign a_free     = (r_a_op == pgal_pkg::OP_FREE);
    assign a_in_range = (r_a_idx < pgal_pkg::IDX_W'(USABLE));
    assign a_prod     = PROD_W'(r_a_idx[pgal_pkg::PAGE_W-1:0]) * PROD_W'(RECIP);
    assign a_free_grp = a_prod[pgal_pkg::RECIP_SHIFT +: GW];

    pgal_find_zero #(.W(NUM_GROUPS), .IW(GW)) u_grp_sel (
        .i_word  (r_full),
        .o_found (g_found),
        .o_index (g_idx)
    );

    assign a_grp  = a_alloc ? g_idx : a_free_grp;
    assign a_ok   = a_alloc ? g_found : a_in_range;
    assign hazard = a_alloc && r_b_vld && (r_b_op == pgal_pkg::OP_ALLOC);

    assign out_free    = !r_o_vld || o_rsp.ready;
    assign adv_b       = r_b_vld && out_free;
    assign adv_a       = r_a_vld && !hazard && (!r_b_vld || adv_b);
    assign rd_en       = adv_a && a_ok && (a_alloc || a_free);
    assign i_req.ready = !r_a_vld || adv_a;

    // ---- word stage: modify and write back ----
    assign b_alloc = (r_b_op == pgal_pkg::OP_ALLOC);
    assign b_free  = (r_b_op == pgal_pkg::OP_FREE);
    assign b_query = (r_b_op == pgal_pkg::OP_QUERY);

    pgal_word_mem #(.DEPTH(NUM_GROUPS), .WIDTH(PAGES_PER_GROUP), .AW(GW)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (a_grp),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_b_grp),
        .i_wr_data (new_word),
        .o_rd_data (word)
    );

    pgal_find_zero #(.W(PAGES_PER_GROUP), .IW(PW)) u_pos_sel (
        .i_word  (word),
        .o_found (w_found),
        .o_index (w_pos)
    );

    assign base  = pgal_pkg::PAGE_W'(r_b_grp * PAGES_PER_GROUP);
    assign f_pos = PW'(r_b_idx - base);

    always_comb begin
        if (b_alloc) begin
            new_word = word | (PAGES_PER_GROUP'(1) << w_pos);
        end else begin
            new_word = word & ~(PAGES_PER_GROUP'(1) << f_pos);
        end
    end

    assign wr_en    = adv_b && r_b_ok && (b_alloc || b_free);
    assign set_full = wr_en && b_alloc && (&new_word);

    always_comb begin
        b_page   = '0;
        b_status = pgal_pkg::ST_OK;
        b_empty  = 1'b0;
        if (b_alloc) begin
            if (r_b_ok) begin
                b_page = base + pgal_pkg::PAGE_W'(w_pos);
            end else begin
                b_status = pgal_pkg::ST_NOFREE;
            end
        end else if (b_free) begin
            if (!r_b_ok) begin
                b_status = pgal_pkg::ST_RANGE;
            end
        end else if (b_query) begin
            b_empty = r_one0 && ((r_nz & ~NUM_GROUPS'(1)) == '0);
        end
    end

    // ---- state update ----
    always_comb begin
        n_full = r_full;
        if (set_full) begin
            n_full[r_b_grp] = 1'b1;
        end
        // younger free wins over an older allocate filling the same group
        if (adv_a && a_free && a_in_range) begin
            n_full[a_free_grp] = 1'b0;
        end
        n_nz   = r_nz;
        n_one0 = r_one0;
        if (wr_en) begin
            n_nz[r_b_grp] = |new_word;
            if (r_b_grp == '0) begin
                n_one0 = (new_word == PAGES_PER_GROUP'(1));
            end
        end
        n_a_vld = i_req.ready ? i_req.valid : r_a_vld;
        n_b_vld = adv_a ? 1'b1 : (adv_b ? 1'b0 : r_b_vld);
        n_o_vld = adv_b ? 1'b1 : (o_rsp.ready ? 1'b0 : r_o_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_full  <= '0;
            r_nz    <= NUM_GROUPS'(1);
            r_one0  <= 1'b1;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_o_vld <= n_o_vld;
            r_full  <= n_full;
            r_nz    <= n_nz;
            r_one0  <= n_one0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_a_op  <= i_req.operation;
            r_a_idx <= i_req.page_index;
        end
        if (adv_a) begin
            r_b_op  <= r_a_op;
            r_b_grp <= a_grp;
            r_b_idx <= r_a_idx[pgal_pkg::PAGE_W-1:0];
            r_b_ok  <= a_ok;
        end
        if (adv_b) begin
            r_o_page   <= b_page;
            r_o_status <= b_status;
            r_o_empty  <= b_empty;
        end
    end

    assign o_rsp.valid          = r_o_vld;
    assign o_rsp.page_index_res = r_o_page;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.is_empty       = r_o_empty;

    `PGAL_ASSERT_NOW(a_alloc_has_room, adv_b && b_alloc && r_b_ok, w_found,
        "allocate committed to a full group word")
    `PGAL_ASSERT_NOW(a_one0_nz, r_one0, r_nz[0], "group 0 flags disagree")
    `PGAL_ASSERT_NOW(a_no_overrun, r_b_vld && !adv_b, !adv_a,
        "word stage overwritten while stalled")

endmodule

[hdl/pgal_find_zero.sv]
// ---------------------------------------------------------------------------
// pgal_find_zero
// Priority encoder: position of the lowest clear bit of a word.
// ---------------------------------------------------------------------------
module pgal_find_zero #(
    parameter int W  = 64,
    parameter int IW = (W > 1) ? $clog2(W) : 1
) (
    input  logic [W-1:0]  i_word,
    output logic          o_found,
    output logic [IW-1:0] o_index
);

    always_comb begin
        o_index = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_index = IW'(i);
            end
        end
    end

    assign o_found = ~&i_word;

endmodule

[hdl/pgal_word_mem.sv]
// ---------------------------------------------------------------------------
// pgal_word_mem
// Group word memory: one write and one registered read per cycle, per-word
// valid bits for the reset image, write-to-read forwarding.
// ---------------------------------------------------------------------------
`include "two_level_bitmap_page_allocator_top_defines.svh"

module pgal_word_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_fwd_data;
    logic             r_fwd;
    logic             r_hit;
    logic             r_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
            r_hit      <= r_vld[i_rd_addr];
            r_zero     <= (i_rd_addr == '0);
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (i_wr_en) begin
            n_vld[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // unwritten words read as the reset image: page 0 held
    assign o_rd_data = r_fwd ? r_fwd_data :
                       r_hit ? r_q        :
                       (r_zero ? WIDTH'(1) : '0);

    `PGAL_ASSERT_NEXT(a_fwd_data, i_rd_en && i_wr_en && (i_wr_addr == i_rd_addr),
        o_rd_data == $past(i_wr_data), "forwarded read data mismatch")
    `PGAL_ASSERT_NEXT(a_wr_valid, i_wr_en, r_vld[$past(i_wr_addr)],
        "written word not marked valid")

endmodule
